// ----- sv/tsa_pkg.sv -----
// tsa_pkg: shared types and constants for the triangle stiffness assembler
// no dependencies; imported by triangle_stiffness_assembler and both testbench files

package tsa_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int IDX_W         = 6;
   localparam int COUNT_W       = 7;
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = 33;
   localparam int PROD_W        = 66;
   localparam int ACC_W         = 67;
   localparam int DM_W          = 66;
   localparam int FRAC_SHIFT    = 23;
   localparam int DIV_W         = DM_W + FRAC_SHIFT;
   localparam int DIV_STEPS     = DIV_W;
   localparam int DIV_CNT_W     = 7;
   localparam int ENTRY_W       = 48;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_MIN = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      FN_CLEAR      = 2'd0,
      FN_WRITE_NODE = 2'd1,
      FN_ADD_ELEM   = 2'd2,
      FN_READ       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_AREA = 2'd1,
      ST_RANGE     = 2'd2,
      ST_SAT       = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_RD_A,
      S_RD_B,
      S_RD_C,
      S_GRAD,
      S_DET1,
      S_DET2,
      S_DET3,
      S_DET_CHK,
      S_NUM1,
      S_NUM2,
      S_NUM3,
      S_DIV_SET,
      S_DIV,
      S_DIV_END,
      S_MAT_WR,
      S_READ,
      S_READ_WAIT,
      S_DONE
   } state_type;

endpackage

// ----- sv/triangle_stiffness_assembler.sv -----
// triangle_stiffness_assembler: global stiffness matrix for linear triangles
// one sequencer around a shared 33x33 multiplier and a shift-subtract divider
// depends on tsa_pkg
//
// Usage: one transaction on req_* gives exactly one transaction on rsp_*.
// req_func selects clear matrix, write node, add element or read entry.
// csr_write_en/csr_write_data set the node count; write it only while idle.
// Only one transaction is in work at a time; req_ready is high in idle.
// An add element computes 9 entries, each set by the 89-step shift-subtract
// divider; an element with a bad corner index or zero area is answered
// without dividing. Clear sweeps all 4096 matrix entries at MAX_NODES = 64.
// After reset the matrix memory is swept to zero, one entry per cycle, with
// req_ready low; csr writes still land.
// A result waits in the rsp output register while rsp_ready is low; the next
// transaction may be accepted meanwhile but its own result holds until the
// output register is free.

module triangle_stiffness_assembler
   import tsa_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [IDX_W-1:0]           req_node_index,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   input  logic [IDX_W-1:0]           req_corner_a,
   input  logic [IDX_W-1:0]           req_corner_b,
   input  logic [IDX_W-1:0]           req_corner_c,
   input  logic [IDX_W-1:0]           req_row_index,
   input  logic [IDX_W-1:0]           req_col_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ENTRY_W-1:0]  rsp_entry_value,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_write_en,
   input  logic [COUNT_W-1:0]         csr_write_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int MAT_AW = 2 * NODE_W;
   localparam int MAT_DEPTH = 1 << MAT_AW;
   localparam int CMP_W = (NODE_W + 1 > COUNT_W) ? NODE_W + 1 : COUNT_W;

   // control
   state_type              state_ff, state_in;
   logic [MAT_AW-1:0]      clr_addr_ff;
   logic                   clr_resp_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   rsp_valid_ff;

   // latched transaction
   func_type               func_ff;
   logic [IDX_W-1:0]       node_idx_ff, ca_ff, cb_ff, cc_ff, row_ff, col_ff;
   logic [COORD_W-1:0]     wx_ff, wy_ff;

   // datapath
   logic [COORD_W-1:0]     node_x_mem [MAX_NODES];
   logic [COORD_W-1:0]     node_y_mem [MAX_NODES];
   logic [ENTRY_W-1:0]     mat_mem [MAT_DEPTH];
   logic [COORD_W-1:0]     node_x_q_ff, node_y_q_ff;
   logic [ENTRY_W-1:0]     mat_q_ff;
   logic signed [COORD_W-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic signed [DIFF_W-1:0]  gx0_ff, gx1_ff, gx2_ff, gy0_ff, gy1_ff, gy2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [DM_W-1:0]        dm_ff, rem_ff;
   logic [DIV_W-1:0]       div_num_ff;
   logic [ENTRY_W-1:0]     quo_ff, contrib_ff;
   logic                   ovf_ff, neg_ff, sat_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [1:0]             i_ff, j_ff;
   logic [ENTRY_W-1:0]     res_entry_ff, rsp_entry_ff;
   status_type             res_status_ff, rsp_status_ff;

   // combinational
   logic                   accept;
   logic signed [DIFF_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic [NODE_W-1:0]      node_raddr;
   logic [MAT_AW-1:0]      mat_raddr, mat_waddr;
   logic                   mat_we, node_we;
   logic [ENTRY_W-1:0]     mat_wdata;
   logic [IDX_W-1:0]       idx_i, idx_j;
   logic [ACC_W-1:0]       acc_mag;
   logic [DM_W:0]          rem_sh;
   logic                   div_ge;
   logic [ENTRY_W:0]       mat_sum;
   logic [ENTRY_W-1:0]     mat_clamped;
   logic                   mat_ovf;
   logic                   corners_ok, rc_ok, node_ok, last_pair;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                   input logic [COUNT_W-1:0] cnt);
      logic [CMP_W-1:0] e;
      e = CMP_W'(idx);
      return (e < CMP_W'(cnt)) && (e < CMP_W'(MAX_NODES));
   endfunction

   function automatic logic signed [DIFF_W-1:0] sel_grad(
      input logic signed [DIFF_W-1:0] g0,
      input logic signed [DIFF_W-1:0] g1,
      input logic signed [DIFF_W-1:0] g2,
      input logic [1:0] sel);
      logic signed [DIFF_W-1:0] r;
      case (sel)
         2'd0:    r = g0;
         2'd1:    r = g1;
         default: r = g2;
      endcase
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] sel_idx(input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c, input logic [1:0] sel);
      logic [IDX_W-1:0] r;
      case (sel)
         2'd0:    r = a;
         2'd1:    r = b;
         default: r = c;
      endcase
      return r;
   endfunction

   assign accept     = req_valid && req_ready;
   assign corners_ok = idx_ok(ca_ff, count_ff) && idx_ok(cb_ff, count_ff)
                       && idx_ok(cc_ff, count_ff);
   assign rc_ok      = idx_ok(row_ff, count_ff) && idx_ok(col_ff, count_ff);
   assign node_ok    = idx_ok(node_idx_ff, count_ff);
   assign last_pair  = (i_ff == 2'd2) && (j_ff == 2'd2);
   assign idx_i      = sel_idx(ca_ff, cb_ff, cc_ff, i_ff);
   assign idx_j      = sel_idx(ca_ff, cb_ff, cc_ff, j_ff);

   assign prod_in    = mul_a * mul_b;
   assign acc_mag    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // one restoring division step
   assign rem_sh     = {rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge     = rem_sh >= {1'b0, dm_ff};

   // saturating accumulate into the matrix entry
   assign mat_sum     = {mat_q_ff[ENTRY_W-1], mat_q_ff} +
                        {contrib_ff[ENTRY_W-1], contrib_ff};
   assign mat_ovf     = mat_sum[ENTRY_W] != mat_sum[ENTRY_W-1];
   assign mat_clamped = !mat_ovf ? mat_sum[ENTRY_W-1:0]
                      : (mat_sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == MAT_AW'(MAT_DEPTH - 1)) begin
               state_in = clr_resp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (func_ff)
               FN_CLEAR:      state_in = S_CLEAR;
               FN_WRITE_NODE: state_in = S_DONE;
               FN_ADD_ELEM:   state_in = corners_ok ? S_RD_A : S_DONE;
               FN_READ:       state_in = rc_ok ? S_READ : S_DONE;
               default:       state_in = S_DONE;
            endcase
         end
         S_RD_A:      state_in = S_RD_B;
         S_RD_B:      state_in = S_RD_C;
         S_RD_C:      state_in = S_GRAD;
         S_GRAD:      state_in = S_DET1;
         S_DET1:      state_in = S_DET2;
         S_DET2:      state_in = S_DET3;
         S_DET3:      state_in = S_DET_CHK;
         S_DET_CHK:   state_in = (acc_ff == '0) ? S_DONE : S_NUM1;
         S_NUM1:      state_in = S_NUM2;
         S_NUM2:      state_in = S_NUM3;
         S_NUM3:      state_in = S_DIV_SET;
         S_DIV_SET:   state_in = S_DIV;
         S_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = S_DIV_END;
         end
         S_DIV_END:   state_in = S_MAT_WR;
         S_MAT_WR:    state_in = last_pair ? S_DONE : S_NUM1;
         S_READ:      state_in = S_READ_WAIT;
         S_READ_WAIT: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      mat_we     = 1'b0;
      mat_waddr  = {NODE_W'(idx_i), NODE_W'(idx_j)};
      mat_wdata  = mat_clamped;
      mat_raddr  = {NODE_W'(idx_i), NODE_W'(idx_j)};
      node_we    = 1'b0;
      node_raddr = NODE_W'(cc_ff);
      mul_a      = sel_grad(gx0_ff, gx1_ff, gx2_ff, i_ff);
      mul_b      = sel_grad(gx0_ff, gx1_ff, gx2_ff, j_ff);
      case (state_ff)
         S_CLEAR: begin
            mat_we    = 1'b1;
            mat_waddr = clr_addr_ff;
            mat_wdata = '0;
         end
         S_IDLE:   req_ready = 1'b1;
         S_DECODE: node_we = (func_ff == FN_WRITE_NODE) && node_ok;
         S_RD_A:   node_raddr = NODE_W'(ca_ff);
         S_RD_B:   node_raddr = NODE_W'(cb_ff);
         S_DET1: begin
            mul_a = gy2_ff;
            mul_b = gx1_ff;
         end
         S_DET2: begin
            mul_a = gy1_ff;
            mul_b = gx2_ff;
         end
         S_NUM2: begin
            mul_a = sel_grad(gy0_ff, gy1_ff, gy2_ff, i_ff);
            mul_b = sel_grad(gy0_ff, gy1_ff, gy2_ff, j_ff);
         end
         S_MAT_WR: mat_we = 1'b1;
         S_READ:   mat_raddr = {NODE_W'(row_ff), NODE_W'(col_ff)};
         default: ;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_x_mem[NODE_W'(node_idx_ff)] <= wx_ff;
         node_y_mem[NODE_W'(node_idx_ff)] <= wy_ff;
      end
      node_x_q_ff <= node_x_mem[node_raddr];
      node_y_q_ff <= node_y_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
      mat_q_ff <= mat_mem[mat_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         count_ff     <= NODE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) count_ff <= csr_write_data;
         if (state_ff == S_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (state_ff == S_DECODE) clr_resp_ff <= (func_ff == FN_CLEAR);
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= func_type'(req_func);
         node_idx_ff <= req_node_index;
         wx_ff       <= req_coord_x;
         wy_ff       <= req_coord_y;
         ca_ff       <= req_corner_a;
         cb_ff       <= req_corner_b;
         cc_ff       <= req_corner_c;
         row_ff      <= req_row_index;
         col_ff      <= req_col_index;
      end
      prod_ff <= prod_in;
      case (state_ff)
         S_CLEAR: begin
            res_entry_ff  <= '0;
            res_status_ff <= ST_OK;
         end
         S_DECODE: begin
            res_entry_ff  <= '0;
            res_status_ff <= (func_ff == FN_WRITE_NODE && node_ok) ? ST_OK : ST_RANGE;
            sat_ff <= 1'b0;
            i_ff   <= 2'd0;
            j_ff   <= 2'd0;
         end
         S_RD_B: begin
            xa_ff <= node_x_q_ff;
            ya_ff <= node_y_q_ff;
         end
         S_RD_C: begin
            xb_ff <= node_x_q_ff;
            yb_ff <= node_y_q_ff;
         end
         S_GRAD: begin
            gx0_ff <= DIFF_W'(yb_ff) - DIFF_W'($signed(node_y_q_ff));
            gx1_ff <= DIFF_W'($signed(node_y_q_ff)) - DIFF_W'(ya_ff);
            gx2_ff <= DIFF_W'(ya_ff) - DIFF_W'(yb_ff);
            gy0_ff <= DIFF_W'($signed(node_x_q_ff)) - DIFF_W'(xb_ff);
            gy1_ff <= DIFF_W'(xa_ff) - DIFF_W'($signed(node_x_q_ff));
            gy2_ff <= DIFF_W'(xb_ff) - DIFF_W'(xa_ff);
         end
         S_DET2, S_NUM2: acc_ff <= ACC_W'(prod_ff);
         S_DET3:  acc_ff <= acc_ff - ACC_W'(prod_ff);
         S_NUM3:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         S_DET_CHK: begin
            dm_ff <= acc_mag[DM_W-1:0];
            if (acc_ff == '0) res_status_ff <= ST_ZERO_AREA;
         end
         S_DIV_SET: begin
            neg_ff     <= acc_ff[ACC_W-1];
            div_num_ff <= {acc_mag[DM_W-1:0], {FRAC_SHIFT{1'b0}}};
            rem_ff     <= '0;
            quo_ff     <= '0;
            ovf_ff     <= 1'b0;
            div_cnt_ff <= '0;
         end
         S_DIV: begin
            rem_ff     <= div_ge ? DM_W'(rem_sh - {1'b0, dm_ff}) : rem_sh[DM_W-1:0];
            div_num_ff <= {div_num_ff[DIV_W-2:0], 1'b0};
            quo_ff     <= {quo_ff[ENTRY_W-2:0], div_ge};
            ovf_ff     <= ovf_ff | quo_ff[ENTRY_W-1];
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         S_DIV_END: begin
            if (ovf_ff || (neg_ff ? (quo_ff > ENTRY_MIN) : quo_ff[ENTRY_W-1])) begin
               sat_ff     <= 1'b1;
               contrib_ff <= neg_ff ? ENTRY_MIN : ENTRY_MAX;
            end else begin
               contrib_ff <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            end
         end
         S_MAT_WR: begin
            if (mat_ovf) sat_ff <= 1'b1;
            if (j_ff == 2'd2) begin
               j_ff <= 2'd0;
               i_ff <= i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
            res_status_ff <= (sat_ff || mat_ovf) ? ST_SAT : ST_OK;
         end
         S_READ_WAIT: begin
            res_entry_ff  <= mat_q_ff;
            res_status_ff <= ST_OK;
         end
         default: ;
      endcase
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_entry_ff  <= res_entry_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_status      = rsp_status_ff;

   // a non-ok result never carries an entry value
   a_err_zero_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_entry_value == '0))
      else $error("error result with nonzero entry");

   // a zero determinant ends the element with the zero-area code
   a_zero_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DET_CHK && acc_ff == '0) |=>
         (state_ff == S_DONE && res_status_ff == ST_ZERO_AREA))
      else $error("zero-area element not reported");

   // divider never runs past its step count
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("divider step count overrun");

   // no new transaction is taken while the matrix is being swept
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("transaction accepted during clear sweep");

endmodule

// ----- test/tsa_result_checker.sv -----
// tsa_result_checker: predicts and checks every response of the stiffness assembler
// watches the req, rsp and csr ports; depends on tsa_pkg

module tsa_result_checker
   import tsa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [IDX_W-1:0]          req_node_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [IDX_W-1:0]          req_corner_a,
   input  logic [IDX_W-1:0]          req_corner_b,
   input  logic [IDX_W-1:0]          req_corner_c,
   input  logic [IDX_W-1:0]          req_row_index,
   input  logic [IDX_W-1:0]          req_col_index,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [ENTRY_W-1:0]        rsp_entry_value,
   input  logic [1:0]                rsp_status,
   input  logic                      csr_write_en,
   input  logic [COUNT_W-1:0]        csr_write_data,
   output int                        error_count,
   output int                        pending_count
);

   typedef struct {
      logic [ENTRY_W-1:0] value;
      status_type         status;
   } entry_result_type;

   localparam longint ENTRY_TOP = 64'sh7FFF_FFFF_FFFF;
   localparam longint ENTRY_BOT = -64'sh8000_0000_0000;

   entry_result_type awaiting_q[$];
   longint         node_x[64];
   longint         node_y[64];
   longint         stiffness[64*64];
   logic [COUNT_W-1:0] node_count;

   function automatic int node_bound();
      return (node_count < 64) ? int'(node_count) : 64;
   endfunction

   function automatic logic signed [127:0] wide_mul(longint a, longint b);
      logic signed [127:0] wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   function automatic status_type assemble_triangle(int ca, int cb, int cc);
      int corner[3];
      longint gx[3], gy[3], contrib[9], sum;
      logic signed [127:0] det, num;
      logic [127:0] dm, mag, quo, lim;
      logic sat, neg;
      corner[0] = ca; corner[1] = cb; corner[2] = cc;
      sat = 1'b0;
      for (int i = 0; i < 3; i++)
         if (corner[i] >= node_bound()) return ST_RANGE;
      det = wide_mul(node_x[cb] - node_x[ca], node_y[cc] - node_y[ca])
          - wide_mul(node_x[cc] - node_x[ca], node_y[cb] - node_y[ca]);
      if (det == 0) return ST_ZERO_AREA;
      dm = (det < 0) ? -det : det;
      gx[0] = node_y[cb] - node_y[cc]; gx[1] = node_y[cc] - node_y[ca];
      gx[2] = node_y[ca] - node_y[cb];
      gy[0] = node_x[cc] - node_x[cb]; gy[1] = node_x[ca] - node_x[cc];
      gy[2] = node_x[cb] - node_x[ca];
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            num = wide_mul(gx[i], gx[j]) + wide_mul(gy[i], gy[j]);
            neg = num < 0;
            mag = neg ? -num : num;
            quo = (mag << FRAC_SHIFT) / dm;
            lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
            if (quo > lim) begin
               sat = 1'b1;
               quo = lim;
            end
            contrib[i*3+j] = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
         end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            sum = stiffness[corner[i]*64 + corner[j]] + contrib[i*3+j];
            if (sum > ENTRY_TOP) begin sum = ENTRY_TOP; sat = 1'b1; end
            if (sum < ENTRY_BOT) begin sum = ENTRY_BOT; sat = 1'b1; end
            stiffness[corner[i]*64 + corner[j]] = sum;
         end
      return sat ? ST_SAT : ST_OK;
   endfunction

   function automatic entry_result_type predict_transaction();
      entry_result_type r;
      r.value  = '0;
      r.status = ST_OK;
      case (func_type'(req_func))
         FN_CLEAR: begin
            foreach (stiffness[k]) stiffness[k] = 0;
         end
         FN_WRITE_NODE: begin
            if (req_node_index >= node_bound()) r.status = ST_RANGE;
            else begin
               node_x[req_node_index] = longint'(req_coord_x);
               node_y[req_node_index] = longint'(req_coord_y);
            end
         end
         FN_ADD_ELEM: r.status = assemble_triangle(int'(req_corner_a),
                                                   int'(req_corner_b),
                                                   int'(req_corner_c));
         FN_READ: begin
            if (req_row_index >= node_bound() || req_col_index >= node_bound())
               r.status = ST_RANGE;
            else r.value = stiffness[req_row_index*64 + req_col_index][ENTRY_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      entry_result_type want;
      if (reset) begin
         foreach (stiffness[k]) stiffness[k] = 0;
         foreach (node_x[k]) begin node_x[k] = 0; node_y[k] = 0; end
         node_count = NODE_COUNT_RESET;
         awaiting_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaiting_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected response value=%h status=%0d",
                           rsp_entry_value, rsp_status);
            end else begin
               want = awaiting_q.pop_front();
               if (rsp_entry_value !== want.value || rsp_status !== want.status) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: value exp %h got %h, status exp %0d got %0d",
                              want.value, rsp_entry_value, want.status, rsp_status);
               end
            end
         end
         if (req_valid && req_ready) awaiting_q.push_back(predict_transaction());
         // register write lands at the same edge as in the block
         if (csr_write_en) node_count = csr_write_data;
      end
      pending_count = awaiting_q.size();
   end

endmodule

// ----- test/tb_triangle_stiffness_assembler.sv -----
// tb_triangle_stiffness_assembler: stimulus and verdict for the stiffness assembler
// depends on tsa_pkg, triangle_stiffness_assembler and tsa_result_checker

module tb_triangle_stiffness_assembler;
   import tsa_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_write_en;
   logic [1:0] req_func, rsp_status;
   logic [IDX_W-1:0] req_node_index, req_corner_a, req_corner_b, req_corner_c;
   logic [IDX_W-1:0] req_row_index, req_col_index;
   logic signed [COORD_W-1:0] req_coord_x, req_coord_y;
   logic signed [ENTRY_W-1:0] rsp_entry_value;
   logic [COUNT_W-1:0] csr_write_data;
   int error_count, pending_count;
   int sender_idle_pct, receiver_idle_pct;
   int sent_count, done_count, idle_cycles, elem_count, read_count;
   int cur_bound;
   bit written[64];

   triangle_stiffness_assembler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_node_index(req_node_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_corner_a(req_corner_a),
      .req_corner_b(req_corner_b), .req_corner_c(req_corner_c),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_entry_value(rsp_entry_value), .rsp_status(rsp_status),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   tsa_result_checker result_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_node_index(req_node_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_corner_a(req_corner_a),
      .req_corner_b(req_corner_b), .req_corner_c(req_corner_c),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_entry_value(rsp_entry_value), .rsp_status(rsp_status),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);

   // watchdog and transaction counters
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sent_count++;
         if (rsp_valid && rsp_ready) done_count++;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_item(func_type f, int nidx, logic [31:0] x, logic [31:0] y,
                            int a, int b, int c, int row, int col);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_func = f;
      req_node_index = IDX_W'(nidx);
      req_coord_x = x;
      req_coord_y = y;
      req_corner_a = IDX_W'(a);
      req_corner_b = IDX_W'(b);
      req_corner_c = IDX_W'(c);
      req_row_index = IDX_W'(row);
      req_col_index = IDX_W'(col);
      do @(posedge clock); while (!req_ready);
      if (f == FN_WRITE_NODE && nidx < cur_bound) written[nidx] = 1'b1;
      if (f == FN_ADD_ELEM) elem_count++;
      if (f == FN_READ) read_count++;
   endtask

   task automatic write_node(int n, logic [31:0] x, logic [31:0] y);
      send_item(FN_WRITE_NODE, n, x, y, 0, 0, 0, 0, 0);
   endtask

   task automatic add_elem(int a, int b, int c);
      send_item(FN_ADD_ELEM, 0, 0, 0, a, b, c, 0, 0);
   endtask

   task automatic read_entry(int r, int c);
      send_item(FN_READ, 0, 0, 0, 0, 0, 0, r, c);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (done_count != sent_count) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_node_count(logic [COUNT_W-1:0] n);
      drain();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = n;
      @(negedge clock);
      csr_write_en = 1'b0;
      cur_bound = (n < 64) ? int'(n) : 64;
   endtask

   function automatic int pick_written();
      int n;
      n = $urandom_range(cur_bound - 1);
      for (int k = 0; k < 64 && !written[n]; k++) n = (n + 1) % cur_bound;
      return n;
   endfunction

   function automatic int pick_index();
      if ($urandom_range(99) < 8) return $urandom_range(63);
      return $urandom_range(cur_bound - 1);
   endfunction

   function automatic logic [31:0] pick_coord();
      if ($urandom_range(99) < 25) return $urandom;
      return $urandom_range(32'h0008_0000) - 32'h0004_0000;
   endfunction

   task automatic random_item();
      int roll, nwritten, a, b, c;
      nwritten = 0;
      for (int k = 0; k < cur_bound; k++) nwritten += written[k];
      roll = $urandom_range(999);
      if (roll < 12) send_item(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      else if (roll < 350 || nwritten < 3)
         write_node(pick_index(), pick_coord(), pick_coord());
      else if (roll < 650) begin
         a = pick_written();
         b = pick_written();
         c = pick_written();
         // a corner beyond the bound is rejected before any node read
         if ($urandom_range(99) < 5 && cur_bound < 64) c = $urandom_range(63, cur_bound);
         else if ($urandom_range(99) < 5) c = a;
         add_elem(a, b, c);
      end else begin
         if ($urandom_range(99) < 60) begin
            a = pick_written();
            b = pick_written();
         end else begin
            a = pick_index();
            b = pick_index();
         end
         read_entry(a, b);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FN_CLEAR;
      req_node_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_corner_a = '0;
      req_corner_b = '0;
      req_corner_c = '0;
      req_row_index = '0;
      req_col_index = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = NODE_COUNT_RESET;
      sender_idle_pct = 21;
      receiver_idle_pct = 81;
      sent_count = 0;
      done_count = 0;
      idle_cycles = 0;
      elem_count = 0;
      read_count = 0;
      cur_bound = 64;
      foreach (written[k]) written[k] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: normal, degenerate, saturating and extreme triangles, clear, range errors
      set_node_count(7'd64);
      write_node(0, 0, 0);
      write_node(1, 32'h0001_0000, 0);
      write_node(2, 0, 32'h0001_0000);
      write_node(3, 32'h0002_0000, 0);
      write_node(4, 32'h7FFF_FFFF, 0);
      write_node(5, 0, 32'h0000_0001);
      write_node(62, 32'h8000_0000, 32'h7FFF_FFFF);
      write_node(63, 32'h7FFF_FFFF, 32'h8000_0000);
      add_elem(0, 1, 2);
      read_entry(0, 0);
      read_entry(2, 1);
      add_elem(0, 0, 1);
      add_elem(0, 1, 3);
      add_elem(0, 4, 5);
      read_entry(4, 4);
      add_elem(62, 63, 2);
      read_entry(63, 63);
      send_item(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      read_entry(0, 0);
      set_node_count(7'd0);
      read_entry(0, 0);
      write_node(0, 0, 0);
      add_elem(0, 1, 2);
      set_node_count(7'd3);
      write_node(3, 0, 0);
      read_entry(2, 5);

      repeat (400) random_item();

      sender_idle_pct = 81;
      receiver_idle_pct = 21;
      set_node_count(7'($urandom_range(4, 63)));
      repeat (200) random_item();
      drain();
      repeat (200) random_item();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_node_count(7'd127);
      repeat (400) random_item();

      drain();
      $display("run covered %0d transactions: %0d element adds, %0d entry reads",
               sent_count, elem_count, read_count);
      $display("node counts 64, 0, 3, random and 127 under three idling patterns");
      if (error_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else begin
         if (pending_count != 0) $display("ERROR: %0d responses never arrived", pending_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
